### hdl/b3inv_pkg.sv
// ----------------------------------------------------------------------------
// b3inv_pkg
// Shared types, widths and index tables for the 3x3 matrix inverse unit.
// ----------------------------------------------------------------------------
package b3inv_pkg;

    // fixed widths of the arithmetic
    localparam int ENTRY_W = 32;   // q16.16 matrix entry
    localparam int ADJ_W   = 64;   // q32.32 adjugate entry
    localparam int DET_W   = 98;   // signed q50.48 determinant
    localparam int MAG_W   = 96;   // determinant magnitude
    localparam int REM_W   = 96;   // divider remainder
    localparam int QUO_W   = 31;   // quotient magnitude bits
    localparam int WIDE_W  = MAG_W + QUO_W;
    localparam int NUM_ENT = 9;
    localparam int DIV_STAGES = QUO_W + 1;

    typedef logic [3:0] idx_t;

    // adjugate entry i = m[PA_X]*m[PA_Y] - m[PB_X]*m[PB_Y], flattened row-major
    localparam idx_t PA_X [NUM_ENT] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
    localparam idx_t PA_Y [NUM_ENT] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
    localparam idx_t PB_X [NUM_ENT] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
    localparam idx_t PB_Y [NUM_ENT] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

    // saturation limits
    localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN   = 32'h8000_0000;
    localparam logic [63:0] DET_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] DET_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] a00;
        logic signed [31:0] a01;
        logic signed [31:0] a02;
        logic signed [31:0] a10;
        logic signed [31:0] a11;
        logic signed [31:0] a12;
        logic signed [31:0] a20;
        logic signed [31:0] a21;
        logic signed [31:0] a22;
    } matrix_t;

    typedef struct packed {
        logic signed [31:0] b00;
        logic signed [31:0] b01;
        logic signed [31:0] b02;
        logic signed [31:0] b10;
        logic signed [31:0] b11;
        logic signed [31:0] b12;
        logic signed [31:0] b20;
        logic signed [31:0] b21;
        logic signed [31:0] b22;
        logic signed [63:0] det_value;
        logic               singular;
    } result_t;

endpackage

### hdl/block3x3_inverse_unit.sv
// ----------------------------------------------------------------------------
// block3x3_inverse_unit
// Pipelined inverse and determinant of one signed q16.16 3x3 matrix per word.
// ----------------------------------------------------------------------------
// Usage:
//   matrix channel: matrix_valid / matrix_stall carry one 3x3 matrix word.
//   result channel: result_valid / result_stall carry the inverse in q16.16
//   (truncated toward zero, saturated), the determinant in saturated q32.32
//   and a singular flag (zero determinant gives zero inverse entries).
//   The pipeline has two multiply/adjugate stages, two determinant
//   stages, one magnitude stage, one saturation check, 31 restoring divide
//   stages (one quotient bit each, nine dividers side by side) and the
//   output register. Throughput is one word per cycle unless a stalled
//   result holds the pipeline; the divide stage chain sets the depth.
//   Reset clears all valid bits; the data registers are not reset.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   matrix_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module block3x3_inverse_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                matrix_valid,
    output logic                matrix_stall,
    input  b3inv_pkg::matrix_t  matrix,
    output logic                result_valid,
    input  logic                result_stall,
    output b3inv_pkg::result_t  result
);

    localparam int N  = b3inv_pkg::NUM_ENT;
    localparam int DS = b3inv_pkg::DIV_STAGES;

    logic adv;
    logic signed [31:0] m_in [N];

    // stage registers
    logic                      s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                      s4_valid_reg, s5_valid_reg;
    logic signed [63:0]        s1_pa_reg [N];
    logic signed [63:0]        s1_pb_reg [N];
    logic signed [31:0]        s1_row_reg [3];
    logic signed [63:0]        s2_adj_reg [N];
    logic signed [31:0]        s2_row_reg [3];
    logic signed [63:0]        s3_hi_reg [3];
    logic signed [64:0]        s3_lo_reg [3];
    logic signed [63:0]        s3_adj_reg [N];
    logic [b3inv_pkg::DET_W-1:0] s4_det_reg;
    logic signed [63:0]        s4_adj_reg [N];
    logic [b3inv_pkg::MAG_W-1:0] s5_dmag_reg;
    logic                      s5_sing_reg;
    logic [63:0]               s5_detv_reg;
    logic [b3inv_pkg::REM_W-1:0] s5_rem_reg [N];
    logic                      s5_neg_reg [N];
    logic                      s5_zero_reg [N];

    // divider chain
    logic                        dv_valid_reg [DS];
    logic [b3inv_pkg::MAG_W-1:0] dv_dmag_reg [DS];
    logic                        dv_sing_reg [DS];
    logic [63:0]                 dv_detv_reg [DS];
    logic [b3inv_pkg::REM_W-1:0] dv_rem_reg [DS][N];
    logic [b3inv_pkg::QUO_W-1:0] dv_q_reg [DS][N];
    logic                        dv_neg_reg [DS][N];
    logic                        dv_zero_reg [DS][N];
    logic                        dv_sat_reg [DS][N];
    logic [b3inv_pkg::REM_W-1:0] dv_rem_next [DS][N];
    logic [b3inv_pkg::QUO_W-1:0] dv_q_next [DS][N];
    logic                        dv_sat_next [N];

    // output register
    logic               result_valid_reg;
    b3inv_pkg::result_t result_reg;
    b3inv_pkg::result_t result_next;

    // global advance: hold everything while a result word is stalled
    assign adv          = !(result_valid_reg && result_stall);
    assign matrix_stall = !adv;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign m_in[0] = matrix.a00;
    assign m_in[1] = matrix.a01;
    assign m_in[2] = matrix.a02;
    assign m_in[3] = matrix.a10;
    assign m_in[4] = matrix.a11;
    assign m_in[5] = matrix.a12;
    assign m_in[6] = matrix.a20;
    assign m_in[7] = matrix.a21;
    assign m_in[8] = matrix.a22;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int k = 0; k < DS; k++)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg    <= matrix_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            dv_valid_reg[0] <= s5_valid_reg;
            for (int k = 1; k < DS; k++)
            begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
            result_valid_reg <= dv_valid_reg[DS-1];
        end
    end

    // stage 1: eighteen 32x32 products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N; i++)
            begin
                s1_pa_reg[i] <= m_in[b3inv_pkg::PA_X[i]] * m_in[b3inv_pkg::PA_Y[i]];
                s1_pb_reg[i] <= m_in[b3inv_pkg::PB_X[i]] * m_in[b3inv_pkg::PB_Y[i]];
            end
            for (int j = 0; j < 3; j++)
            begin
                s1_row_reg[j] <= m_in[j];
            end
        end
    end

    // stage 2: adjugate entries
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N; i++)
            begin
                s2_adj_reg[i] <= s1_pa_reg[i] - s1_pb_reg[i];
            end
            s2_row_reg <= s1_row_reg;
        end
    end

    // stage 3: partial products of first adjugate column and row 0
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s3_hi_reg[j] <= $signed(s2_adj_reg[3*j][63:32]) * s2_row_reg[j];
                s3_lo_reg[j] <= $signed({1'b0, s2_adj_reg[3*j][31:0]}) * s2_row_reg[j];
            end
            s3_adj_reg <= s2_adj_reg;
        end
    end

    // stage 4: determinant sum
    always_ff @(posedge clk)
    begin
        logic [b3inv_pkg::DET_W-1:0] acc;
        if (adv)
        begin
            acc = '0;
            for (int j = 0; j < 3; j++)
            begin
                acc = acc + {{2{s3_hi_reg[j][63]}}, s3_hi_reg[j], 32'b0}
                          + {{33{s3_lo_reg[j][64]}}, s3_lo_reg[j]};
            end
            s4_det_reg <= acc;
            s4_adj_reg <= s3_adj_reg;
        end
    end

    // stage 5: magnitudes, signs, determinant output
    always_ff @(posedge clk)
    begin
        logic                        dneg;
        logic [b3inv_pkg::DET_W-1:0] dabs;
        logic [79:0]                 shifted;
        logic [63:0]                 amag;
        if (adv)
        begin
            dneg    = s4_det_reg[b3inv_pkg::DET_W-1];
            dabs    = dneg ? -s4_det_reg : s4_det_reg;
            shifted = dabs[95:16];
            s5_dmag_reg <= dabs[b3inv_pkg::MAG_W-1:0];
            s5_sing_reg <= (s4_det_reg == '0);
            if (!dneg)
            begin
                s5_detv_reg <= (shifted[79:63] != '0) ? b3inv_pkg::DET_MAX : shifted[63:0];
            end
            else
            begin
                s5_detv_reg <= (shifted > {16'b0, b3inv_pkg::DET_MIN}) ? b3inv_pkg::DET_MIN
                                                                      : -shifted[63:0];
            end
            for (int i = 0; i < N; i++)
            begin
                amag = s4_adj_reg[i][63] ? -s4_adj_reg[i] : s4_adj_reg[i];
                s5_rem_reg[i]  <= {amag, 32'b0};
                s5_neg_reg[i]  <= s4_adj_reg[i][63] ^ dneg;
                s5_zero_reg[i] <= (s4_adj_reg[i] == '0);
            end
        end
    end

    // divider: saturation check, then one quotient bit per stage
    always_comb
    begin
        logic [b3inv_pkg::WIDE_W-1:0] t;
        for (int i = 0; i < N; i++)
        begin
            dv_sat_next[i]    = ({31'b0, s5_rem_reg[i]} >= {s5_dmag_reg, 31'b0});
            dv_rem_next[0][i] = s5_rem_reg[i];
            dv_q_next[0][i]   = '0;
        end
        for (int k = 1; k < DS; k++)
        begin
            for (int i = 0; i < N; i++)
            begin
                t = {31'b0, dv_dmag_reg[k-1]} << (DS - 1 - k);
                dv_rem_next[k][i] = dv_rem_reg[k-1][i];
                dv_q_next[k][i]   = dv_q_reg[k-1][i];
                if ({31'b0, dv_rem_reg[k-1][i]} >= t)
                begin
                    dv_rem_next[k][i] = dv_rem_reg[k-1][i] - t[b3inv_pkg::REM_W-1:0];
                    dv_q_next[k][i][DS-1-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_dmag_reg[0] <= s5_dmag_reg;
            dv_sing_reg[0] <= s5_sing_reg;
            dv_detv_reg[0] <= s5_detv_reg;
            for (int i = 0; i < N; i++)
            begin
                dv_neg_reg[0][i]  <= s5_neg_reg[i];
                dv_zero_reg[0][i] <= s5_zero_reg[i];
                dv_sat_reg[0][i]  <= dv_sat_next[i];
            end
            for (int k = 1; k < DS; k++)
            begin
                dv_dmag_reg[k] <= dv_dmag_reg[k-1];
                dv_sing_reg[k] <= dv_sing_reg[k-1];
                dv_detv_reg[k] <= dv_detv_reg[k-1];
                dv_neg_reg[k]  <= dv_neg_reg[k-1];
                dv_zero_reg[k] <= dv_zero_reg[k-1];
                dv_sat_reg[k]  <= dv_sat_reg[k-1];
            end
            dv_rem_reg <= dv_rem_next;
            dv_q_reg   <= dv_q_next;
        end
    end

    // output formatting
    always_comb
    begin
        logic [31:0] b [N];
        logic        sing;
        sing = dv_sing_reg[DS-1];
        for (int i = 0; i < N; i++)
        begin
            if (sing || dv_zero_reg[DS-1][i])
            begin
                b[i] = '0;
            end
            else if (dv_sat_reg[DS-1][i])
            begin
                b[i] = dv_neg_reg[DS-1][i] ? b3inv_pkg::Q_MIN : b3inv_pkg::Q_MAX;
            end
            else
            begin
                b[i] = dv_neg_reg[DS-1][i] ? -{1'b0, dv_q_reg[DS-1][i]}
                                           : {1'b0, dv_q_reg[DS-1][i]};
            end
        end
        result_next.b00       = b[0];
        result_next.b01       = b[1];
        result_next.b02       = b[2];
        result_next.b10       = b[3];
        result_next.b11       = b[4];
        result_next.b12       = b[5];
        result_next.b20       = b[6];
        result_next.b21       = b[7];
        result_next.b22       = b[8];
        result_next.det_value = sing ? 64'sd0 : dv_detv_reg[DS-1];
        result_next.singular  = sing;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    // a finished, unsaturated quotient of entry 0 leaves a remainder below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[DS-1] && !dv_sing_reg[DS-1] && !dv_sat_reg[DS-1][0]
        |-> dv_rem_reg[DS-1][0] < {dv_dmag_reg[DS-1]})
        else $error("divider remainder not below divisor");

    // singular flag travels with a zero determinant magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[DS-1] |-> (dv_sing_reg[DS-1] == (dv_dmag_reg[DS-1] == '0)))
        else $error("singular flag out of step with determinant");

    // a singular result carries a zero determinant and zero b00 and b22 entries
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.singular
        |-> result_reg.det_value == 64'sd0 && result_reg.b00 == 32'sd0
            && result_reg.b22 == 32'sd0)
        else $error("singular result with nonzero fields");

endmodule
